### design/olist_pkg.sv
// ----------------------------------------------------------------------------
// olist_pkg
// shared types and constants of the ordered list engine
// ----------------------------------------------------------------------------
package olist_pkg;

  localparam int OLIST_CAPACITY = 64;

  localparam int VALUE_W  = 32;
  localparam int POS_W    = 7;
  localparam int REQ_W    = 3;
  localparam int STATUS_W = 2;
  localparam int FIDX_W   = 6;
  localparam int TOTAL_W  = 7;

  // request codes on the input channel
  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 3'd0,
    REQ_INSERT = 3'd1,
    REQ_DELETE = 3'd2,
    REQ_DELVAL = 3'd3,
    REQ_FIND   = 3'd4,
    REQ_CLEAR  = 3'd5
  } req_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // per-cycle operation broadcast to every cell
  typedef enum logic [2:0] {
    C_HOLD   = 3'd0,
    C_APPEND = 3'd1,
    C_INSERT = 3'd2,
    C_DELETE = 3'd3,
    C_MARK   = 3'd4,
    C_BUBBLE = 3'd5,
    C_FSHIFT = 3'd6
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     phase;
  } cell_cmd_t;

  // summary of the cell row seen by the controller
  typedef struct packed {
    logic any_hole;
    logic any_mtch;
    logic head_mtch;
    logic drop;
  } chain_stat_t;

endpackage

### design/olist_cell.sv
// ----------------------------------------------------------------------------
// olist_cell
// one list slot: entry value, delete mark and find mark
// ----------------------------------------------------------------------------
module olist_cell #(
  parameter int CAPACITY = olist_pkg::OLIST_CAPACITY,
  parameter int IDX      = 0,
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  olist_pkg::cell_cmd_t          cmd,
  input  logic [CW-1:0]                 cnt,
  input  logic [olist_pkg::POS_W-1:0]   pos,
  input  logic [olist_pkg::VALUE_W-1:0] value,
  input  logic [olist_pkg::VALUE_W-1:0] left_data,
  input  logic                          left_hole,
  input  logic [olist_pkg::VALUE_W-1:0] right_data,
  input  logic                          right_hole,
  input  logic                          right_mtch,
  output logic [olist_pkg::VALUE_W-1:0] data,
  output logic                          hole,
  output logic                          mtch,
  output logic                          drop
);

  localparam logic [31:0] I32 = 32'(IDX);
  localparam logic        PAR = I32[0];

  logic [olist_pkg::VALUE_W-1:0] data_r, data_nxt;
  logic                          hole_r, hole_nxt;
  logic                          mtch_r, mtch_nxt;
  logic [31:0]                   c32, p32;
  logic                          hit;

  assign c32 = 32'(cnt);
  assign p32 = 32'(pos);
  assign hit = (I32 < c32) && (data_r == value);

  always_comb begin
    data_nxt = data_r;
    hole_nxt = hole_r;
    mtch_nxt = mtch_r;
    drop     = 1'b0;
    case (cmd.op)
      olist_pkg::C_APPEND: begin
        if (I32 == c32) data_nxt = value;
      end
      olist_pkg::C_INSERT: begin
        if (I32 == p32) begin
          data_nxt = value;
        end else if (I32 > p32 && I32 <= c32) begin
          data_nxt = left_data;
        end
      end
      olist_pkg::C_DELETE: begin
        if (I32 >= p32 && I32 + 32'd1 < c32) data_nxt = right_data;
      end
      olist_pkg::C_MARK: begin
        hole_nxt = hit;
        mtch_nxt = hit;
      end
      olist_pkg::C_BUBBLE: begin
        // odd-even exchange: marked entries move up, kept entries move down
        if (cmd.phase == PAR && hole_r && !right_hole && I32 + 32'd1 < c32) begin
          data_nxt = right_data;
          hole_nxt = 1'b0;
        end else if (cmd.phase != PAR && left_hole && !hole_r && I32 < c32) begin
          data_nxt = left_data;
          hole_nxt = 1'b1;
        end else if (hole_r && I32 + 32'd1 == c32) begin
          // marked entry reached the end of the list, drop it
          hole_nxt = 1'b0;
          drop     = 1'b1;
        end
      end
      olist_pkg::C_FSHIFT: begin
        mtch_nxt = right_mtch;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (!rst_n) begin
      hole_r <= 1'b0;
      mtch_r <= 1'b0;
    end else begin
      hole_r <= hole_nxt;
      mtch_r <= mtch_nxt;
    end
  end

  assign data = data_r;
  assign hole = hole_r;
  assign mtch = mtch_r;

endmodule

### design/olist_ctrl.sv
// ----------------------------------------------------------------------------
// olist_ctrl
// request decode, entry count, sequencer and result register
// ----------------------------------------------------------------------------
module olist_ctrl #(
  parameter int CAPACITY = olist_pkg::OLIST_CAPACITY,
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [olist_pkg::REQ_W-1:0]      req_type,
  input  logic [olist_pkg::POS_W-1:0]      position,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [olist_pkg::STATUS_W-1:0]   status,
  output logic                             found,
  output logic [olist_pkg::FIDX_W-1:0]     found_index,
  output logic [olist_pkg::TOTAL_W-1:0]    entry_total,
  input  olist_pkg::chain_stat_t           stat,
  output olist_pkg::cell_cmd_t             cmd,
  output logic [CW-1:0]                    cnt
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_BUBBLE = 3'b010,
    S_FIND   = 3'b100
  } state_t;

  localparam logic [31:0] CAP32 = 32'(CAPACITY);

  state_t                          state_r, state_nxt;
  logic [CW-1:0]                   cnt_r, cnt_nxt;
  logic [CW-1:0]                   idx_r, idx_nxt;
  logic                            phase_r, phase_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [olist_pkg::STATUS_W-1:0]  status_r, res_status;
  logic                            found_r, res_found;
  logic [olist_pkg::FIDX_W-1:0]    fidx_r;
  logic [olist_pkg::TOTAL_W-1:0]   total_r;
  logic [CW-1:0]                   res_idx;
  logic                            res_ld;
  logic                            out_free;
  logic                            acc;
  logic [31:0]                     c32, p32, idx32, tot32;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign acc       = in_tvalid && in_tready;
  assign c32       = 32'(cnt_r);
  assign p32       = 32'(position);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    phase_nxt  = phase_r;
    res_ld     = 1'b0;
    res_status = olist_pkg::ST_OK;
    res_found  = 1'b0;
    res_idx    = '0;
    cmd.op     = olist_pkg::C_HOLD;
    cmd.phase  = phase_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (req_type)
            olist_pkg::REQ_APPEND: begin
              res_ld = 1'b1;
              if (c32 >= CAP32) begin
                res_status = olist_pkg::ST_FULL;
              end else begin
                cmd.op  = olist_pkg::C_APPEND;
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            olist_pkg::REQ_INSERT: begin
              res_ld = 1'b1;
              if (p32 > c32) begin
                res_status = olist_pkg::ST_RANGE;
              end else if (c32 >= CAP32) begin
                res_status = olist_pkg::ST_FULL;
              end else begin
                cmd.op  = olist_pkg::C_INSERT;
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            olist_pkg::REQ_DELETE: begin
              res_ld = 1'b1;
              if (p32 >= c32) begin
                res_status = olist_pkg::ST_RANGE;
              end else begin
                cmd.op  = olist_pkg::C_DELETE;
                cnt_nxt = cnt_r - CW'(1);
              end
            end
            olist_pkg::REQ_DELVAL: begin
              cmd.op    = olist_pkg::C_MARK;
              phase_nxt = 1'b0;
              state_nxt = S_BUBBLE;
            end
            olist_pkg::REQ_FIND: begin
              cmd.op    = olist_pkg::C_MARK;
              idx_nxt   = '0;
              state_nxt = S_FIND;
            end
            olist_pkg::REQ_CLEAR: begin
              res_ld  = 1'b1;
              cnt_nxt = '0;
            end
            default: begin
              res_ld = 1'b1;
            end
          endcase
        end
      end
      S_BUBBLE: begin
        if (!stat.any_hole) begin
          if (out_free) begin
            res_ld    = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.op    = olist_pkg::C_BUBBLE;
          phase_nxt = !phase_r;
          if (stat.drop) cnt_nxt = cnt_r - CW'(1);
        end
      end
      S_FIND: begin
        if (!stat.any_mtch || stat.head_mtch) begin
          if (out_free) begin
            res_ld    = 1'b1;
            res_found = stat.head_mtch;
            res_idx   = stat.head_mtch ? idx_r : '0;
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.op  = olist_pkg::C_FSHIFT;
          idx_nxt = idx_r + CW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = res_ld ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  assign idx32         = 32'(res_idx);
  assign tot32         = 32'(cnt_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ld) begin
      status_r <= res_status;
      found_r  <= res_found;
      fidx_r   <= idx32[olist_pkg::FIDX_W-1:0];
      total_r  <= tot32[olist_pkg::TOTAL_W-1:0];
    end
  end

  assign out_tvalid  = out_valid_r;
  assign status      = status_r;
  assign found       = found_r;
  assign found_index = fidx_r;
  assign entry_total = total_r;
  assign cnt         = cnt_r;

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= CAP32)
    else $error("entry count above capacity");

  a_bubble_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_BUBBLE |=> cnt_r <= $past(cnt_r))
    else $error("count grew while compacting");

  a_multi_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (req_type == olist_pkg::REQ_FIND || req_type == olist_pkg::REQ_DELVAL)
      |=> state_r != S_IDLE)
    else $error("multi-cycle request did not start");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && found_r |-> status_r == olist_pkg::ST_OK)
    else $error("found flag with bad status");

endmodule

### design/ordered_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_list_engine
// ordered list of signed 32-bit values held in a row of register cells
// ----------------------------------------------------------------------------
// usage:
//   one request transaction on the in_ channel gives exactly one result
//   transaction on the out_ channel, in order.
//   append, insert, delete at position, clear and unused codes finish in the
//   accept cycle; the result sits in the output register from the next cycle.
//   find compares all cells at once, then shifts the match bits toward cell
//   zero one step a cycle: a first match at position k is reported with index
//   k once its bit reaches cell zero, no match right after the compare.
//   delete value marks all matches, then an odd-even exchange along the cell
//   row moves marked entries to the top, where they drop off one per cycle.
//   a new request is taken only when the sequencer is idle and the output
//   register is empty or being drained, so a stalled receiver holds back the
//   input while one finished result waits in the output register.
//   reset empties the list (count zero) and the output register; cell values
//   are not cleared, they are only read below the count.
// ----------------------------------------------------------------------------
module ordered_list_engine #(
  parameter int CAPACITY = olist_pkg::OLIST_CAPACITY
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // req_type[2:0], position[9:3], value[41:10], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // status[1:0], found[2], found_index[8:3], entry_total[15:9]
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int VW = olist_pkg::VALUE_W;

  logic [olist_pkg::REQ_W-1:0]    req_type;
  logic [olist_pkg::POS_W-1:0]    position;
  logic [VW-1:0]                  value;
  logic [olist_pkg::STATUS_W-1:0] status;
  logic                           found;
  logic [olist_pkg::FIDX_W-1:0]   found_index;
  logic [olist_pkg::TOTAL_W-1:0]  entry_total;

  olist_pkg::cell_cmd_t           cmd;
  olist_pkg::chain_stat_t         stat;
  logic [CW-1:0]                  cnt;

  // per-cell views of the row
  logic [VW-1:0]       data_w [CAPACITY];
  logic [CAPACITY-1:0] hole_w;
  logic [CAPACITY-1:0] mtch_w;
  logic [CAPACITY-1:0] drop_w;

  // unpack the request transaction
  assign req_type = in_tdata[2:0];
  assign position = in_tdata[9:3];
  assign value    = in_tdata[41:10];

  // cell row: each cell talks only to its two neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VW-1:0] left_data, right_data;
    logic          left_hole, right_hole, right_mtch;

    if (i == 0) begin : g_first
      assign left_data = '0;
      assign left_hole = 1'b0;
    end else begin : g_mid_l
      assign left_data = data_w[i-1];
      assign left_hole = hole_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data = '0;
      assign right_hole = 1'b0;
      assign right_mtch = 1'b0;
    end else begin : g_mid_r
      assign right_data = data_w[i+1];
      assign right_hole = hole_w[i+1];
      assign right_mtch = mtch_w[i+1];
    end

    olist_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .cnt        (cnt),
      .pos        (position),
      .value      (value),
      .left_data  (left_data),
      .left_hole  (left_hole),
      .right_data (right_data),
      .right_hole (right_hole),
      .right_mtch (right_mtch),
      .data       (data_w[i]),
      .hole       (hole_w[i]),
      .mtch       (mtch_w[i]),
      .drop       (drop_w[i])
    );
  end

  // row summary for the sequencer
  assign stat.any_hole  = |hole_w;
  assign stat.any_mtch  = |mtch_w;
  assign stat.head_mtch = mtch_w[0];
  assign stat.drop      = |drop_w;

  olist_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .req_type    (req_type),
    .position    (position),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .status      (status),
    .found       (found),
    .found_index (found_index),
    .entry_total (entry_total),
    .stat        (stat),
    .cmd         (cmd),
    .cnt         (cnt)
  );

  // pack the result transaction
  assign out_tdata = {entry_total, found_index, found, status};

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking testbench for the ordered list engine
// ----------------------------------------------------------------------------
// request transactions go in on the in_ stream and each one is applied to a
// local copy of the list. That gives the result the block should return.
// Every out_ transaction is checked against the oldest pending result.
// A short directed sequence comes first: empty list, duplicates, both ends,
// out-of-range positions, spare codes and clear. Random requests follow. They
// are generated a few at a time from the current list, so positions are
// mostly valid and values often hit entries. Episodes that favor growth fill
// the list to capacity, and episodes that favor deletion drain it again.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int RAND_ITEMS  = 1550;
  localparam int DRAIN_WAIT  = 300;      // > worst delete-value pass on a full list
  localparam int CYCLE_LIMIT = 2000000;
  localparam int MAX_REPORTS = 10;

  // unused request codes, accepted and ignored by the block
  localparam logic [olist_pkg::REQ_W-1:0] REQ_SPARE_LO = 3'd6;
  localparam logic [olist_pkg::REQ_W-1:0] REQ_SPARE_HI = 3'd7;

  // one request as packed into in_tdata, lowest field last
  typedef struct packed {
    logic signed [olist_pkg::VALUE_W-1:0] value;
    logic [olist_pkg::POS_W-1:0]          pos;
    logic [olist_pkg::REQ_W-1:0]          kind;
  } list_req_t;

  // one result as packed into out_tdata, lowest field last
  typedef struct packed {
    logic [olist_pkg::TOTAL_W-1:0]  total;
    logic [olist_pkg::FIDX_W-1:0]   fidx;
    logic                           found;
    logic [olist_pkg::STATUS_W-1:0] status;
  } list_res_t;

  // request mixes for random episodes
  typedef enum int {GROW_BIAS, EVEN_BIAS, SHRINK_BIAS} bias_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // req_type[2:0], position[9:3], value[41:10], zero pad
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // status[1:0], found[2], found_index[8:3], entry_total[15:9]

  // local copy of the list contents and length
  logic signed [olist_pkg::VALUE_W-1:0] list_vals [olist_pkg::OLIST_CAPACITY];
  int list_len = 0;

  list_req_t req_queue[$];         // requests waiting for the driver
  list_res_t expected_results[$];  // results owed by the block, oldest first

  int n_directed     = 0;
  int reqs_accepted  = 0;
  int results_seen   = 0;
  int err_count      = 0;
  int cycle_count    = 0;
  int n_full         = 0;
  int n_range        = 0;
  int n_find_hits    = 0;
  int n_vals_removed = 0;
  int peak_len       = 0;

  ordered_list_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // list behavior: apply one request to the local list, return its result
  // ---------------------------------------------------------------------------
  function automatic list_res_t apply_to_list(list_req_t rq);
    list_res_t rs;
    int keep;
    int p;
    rs = '0;
    rs.status = olist_pkg::ST_OK;
    p = int'(rq.pos);
    case (rq.kind)
      olist_pkg::REQ_APPEND: begin
        if (list_len >= olist_pkg::OLIST_CAPACITY) begin
          rs.status = olist_pkg::ST_FULL;
        end else begin
          list_vals[list_len] = rq.value;
          list_len++;
        end
      end
      olist_pkg::REQ_INSERT: begin
        // range is checked before full
        if (p > list_len) begin
          rs.status = olist_pkg::ST_RANGE;
        end else if (list_len >= olist_pkg::OLIST_CAPACITY) begin
          rs.status = olist_pkg::ST_FULL;
        end else begin
          for (int i = list_len; i > p; i--) list_vals[i] = list_vals[i-1];
          list_vals[p] = rq.value;
          list_len++;
        end
      end
      olist_pkg::REQ_DELETE: begin
        if (p >= list_len) begin
          rs.status = olist_pkg::ST_RANGE;
        end else begin
          for (int i = p; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
          list_len--;
        end
      end
      olist_pkg::REQ_DELVAL: begin
        // every match goes, neighbors included; survivors keep their order
        keep = 0;
        for (int i = 0; i < list_len; i++) begin
          if (list_vals[i] != rq.value) begin
            list_vals[keep] = list_vals[i];
            keep++;
          end
        end
        list_len = keep;
      end
      olist_pkg::REQ_FIND: begin
        for (int i = 0; i < list_len; i++) begin
          if (list_vals[i] == rq.value) begin
            rs.found = 1'b1;
            rs.fidx  = i[olist_pkg::FIDX_W-1:0];
            break;
          end
        end
      end
      olist_pkg::REQ_CLEAR: list_len = 0;
      default: ;  // spare codes leave everything alone
    endcase
    rs.total = list_len[olist_pkg::TOTAL_W-1:0];
    return rs;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void push_req(logic [olist_pkg::REQ_W-1:0] kind, int pos,
                                   logic [31:0] value);
    list_req_t rq;
    rq.kind  = kind;
    rq.pos   = pos[olist_pkg::POS_W-1:0];
    rq.value = value;
    req_queue.push_back(rq);
  endfunction

  function automatic logic [olist_pkg::REQ_W-1:0] pick_kind(bias_e bias);
    int c_app, c_ins, c_del, c_dv, c_fnd, c_spr;
    int r;
    r = $urandom_range(99);
    case (bias)
      GROW_BIAS: begin
        c_app = 46; c_ins = 78; c_del = 83; c_dv = 87; c_fnd = 97; c_spr = 99;
      end
      EVEN_BIAS: begin
        c_app = 20; c_ins = 40; c_del = 56; c_dv = 68; c_fnd = 90; c_spr = 96;
      end
      default: begin
        c_app = 8; c_ins = 16; c_del = 50; c_dv = 72; c_fnd = 92; c_spr = 96;
      end
    endcase
    if (r < c_app) return olist_pkg::REQ_APPEND;
    if (r < c_ins) return olist_pkg::REQ_INSERT;
    if (r < c_del) return olist_pkg::REQ_DELETE;
    if (r < c_dv)  return olist_pkg::REQ_DELVAL;
    if (r < c_fnd) return olist_pkg::REQ_FIND;
    if (r < c_spr) return $urandom_range(1) ? REQ_SPARE_HI : REQ_SPARE_LO;
    return olist_pkg::REQ_CLEAR;
  endfunction

  // shaped from the current list: mostly valid positions, frequent value hits
  function automatic list_req_t make_request(bias_e bias);
    list_req_t rq;
    int lim;
    int r;
    rq.kind = pick_kind(bias);
    if (rq.kind == olist_pkg::REQ_INSERT || rq.kind == olist_pkg::REQ_DELETE) begin
      lim = (rq.kind == olist_pkg::REQ_INSERT) ? list_len : list_len - 1;
      if (lim < 0) lim = 0;
      r = $urandom_range(99);
      if (r < 70)      rq.pos = olist_pkg::POS_W'($urandom_range(lim, 0));
      else if (r < 85) rq.pos = olist_pkg::POS_W'(lim + $urandom_range(1));  // last valid or one past
      else             rq.pos = olist_pkg::POS_W'($urandom_range(127, 0));
    end else begin
      rq.pos = olist_pkg::POS_W'($urandom_range(127, 0));
    end
    r = $urandom_range(99);
    if (r < 35) begin
      // small pool so duplicates pile up
      case ($urandom_range(5))
        0: rq.value = 32'h0000_0000;
        1: rq.value = 32'hffff_ffff;
        2: rq.value = 32'h7fff_ffff;
        3: rq.value = 32'h8000_0000;
        4: rq.value = 32'h0000_0005;
        default: rq.value = 32'h0000_1234;
      endcase
    end else if (r < 65 && list_len > 0) begin
      rq.value = list_vals[$urandom_range(list_len - 1, 0)];
    end else begin
      rq.value = $urandom;
    end
    return rq;
  endfunction

  // idle percentage by test phase: sender light / receiver heavy, then swapped,
  // then no idling at all
  function automatic int idle_pct(bit sender);
    int third;
    third = (n_directed + RAND_ITEMS) / 3;
    if (reqs_accepted < third)     return sender ? 10 : 86;
    if (reqs_accepted < 2 * third) return sender ? 86 : 10;
    return 0;
  endfunction

  function automatic void note_error(string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("[%0d] %s", cycle_count, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: predicts on each accepted request, then offers the next one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : req_driver
    list_res_t rs;
    int prev_len;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        prev_len = list_len;
        rs = apply_to_list(list_req_t'(in_tdata[41:0]));
        expected_results.push_back(rs);
        reqs_accepted++;
        if (rs.status == olist_pkg::ST_FULL)  n_full++;
        if (rs.status == olist_pkg::ST_RANGE) n_range++;
        if (rs.found) n_find_hits++;
        if (in_tdata[2:0] == olist_pkg::REQ_DELVAL && list_len < prev_len)
          n_vals_removed++;
        if (list_len > peak_len) peak_len = list_len;
      end
      // hold the current transaction until it is taken
      if (!in_tvalid || in_tready) begin
        if (req_queue.size() > 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= {6'b0, req_queue.pop_front()};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks every result transaction against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : res_monitor
    list_res_t got;
    list_res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = list_res_t'(out_tdata);
        results_seen++;
        if (expected_results.size() == 0) begin
          note_error($sformatf("unexpected result: status %0d found %0d idx %0d total %0d",
                               got.status, got.found, got.fidx, got.total));
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.found !== want.found ||
              got.fidx !== want.fidx || got.total !== want.total)
            note_error($sformatf({"result %0d mismatch: status %0d/%0d found %0d/%0d ",
                                  "idx %0d/%0d total %0d/%0d (expected/actual)"},
                                 results_seen, want.status, got.status, want.found,
                                 got.found, want.fidx, got.fidx, want.total, got.total));
        end
      end
      out_tready <= ($urandom_range(99) >= idle_pct(1'b0));
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout: %0d requests taken, %0d results outstanding",
               reqs_accepted, expected_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence: reset, directed requests, random episodes, drain, verdict
  // ---------------------------------------------------------------------------
  initial begin
    bias_e bias;
    int ep_end;
    bias = GROW_BIAS;
    ep_end = 0;

    // empty list corner cases
    push_req(olist_pkg::REQ_FIND,   0,   32'h0000_0005);
    push_req(olist_pkg::REQ_DELETE, 0,   32'h0000_0000);
    push_req(olist_pkg::REQ_DELVAL, 0,   32'h0000_0005);
    push_req(olist_pkg::REQ_INSERT, 1,   32'h0000_0001);
    // extremes and a run of adjacent duplicates
    push_req(olist_pkg::REQ_APPEND, 0,   32'h7fff_ffff);
    push_req(olist_pkg::REQ_APPEND, 0,   32'h8000_0000);
    push_req(olist_pkg::REQ_APPEND, 0,   32'h0000_0005);
    push_req(olist_pkg::REQ_APPEND, 0,   32'h0000_0005);
    push_req(olist_pkg::REQ_APPEND, 0,   32'h0000_0005);
    // insert at the head and at the tail, then past the tail
    push_req(olist_pkg::REQ_INSERT, 0,   32'h0000_0000);
    push_req(olist_pkg::REQ_INSERT, 6,   32'hffff_ffff);
    push_req(olist_pkg::REQ_INSERT, 127, 32'h0000_0003);
    push_req(olist_pkg::REQ_INSERT, 8,   32'h0000_0003);
    push_req(olist_pkg::REQ_FIND,   0,   32'h0000_0005);
    push_req(olist_pkg::REQ_FIND,   127, 32'h8000_0000);
    // remove all adjacent matches, then a value that is absent
    push_req(olist_pkg::REQ_DELVAL, 0,   32'h0000_0005);
    push_req(olist_pkg::REQ_DELVAL, 0,   32'h0000_3039);
    push_req(olist_pkg::REQ_DELETE, 127, 32'h0000_0000);
    push_req(olist_pkg::REQ_DELETE, 4,   32'h0000_0000);
    push_req(olist_pkg::REQ_DELETE, 3,   32'h0000_0000);
    push_req(olist_pkg::REQ_DELETE, 0,   32'h0000_0000);
    push_req(REQ_SPARE_LO, 127, 32'hffff_ffff);
    push_req(REQ_SPARE_HI, 0,   32'h0000_0000);
    push_req(olist_pkg::REQ_CLEAR,  0,   32'h0000_0000);
    push_req(olist_pkg::REQ_FIND,   0,   32'h7fff_ffff);
    n_directed = req_queue.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // random episodes, generated a few requests ahead of the driver
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == ep_end) begin
        bias   = (n == 0) ? GROW_BIAS : bias_e'($urandom_range(2));
        ep_end = n + $urandom_range(90, 30);
      end
      while (req_queue.size() >= 4) @(negedge clk);
      req_queue.push_back(make_request(bias));
    end

    while (req_queue.size() > 0 || in_tvalid || expected_results.size() > 0)
      @(posedge clk);
    // let any stray result show up
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d requests, %0d results checked, %0d mismatches; peak length %0d",
             reqs_accepted, results_seen, err_count, peak_len);
    $display("list full %0d, out of range %0d, find hits %0d, value deletes that removed %0d",
             n_full, n_range, n_find_hits, n_vals_removed);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
design/olist_pkg.sv
design/olist_cell.sv
design/olist_ctrl.sv
design/ordered_list_engine.sv
dv/tb_top.sv
